// ===== sv/stlg_pkg.sv =====
// shared types, constants and glyph tables for the segment text line generator
// no dependencies
package stlg_pkg;

  localparam int DEF_COORD_WIDTH = 16;

  localparam int SEG_COUNT = 9;
  localparam int SEG_IDX_W = 4;
  localparam int FRAC_W    = 9;
  localparam int SIZE_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COLOR_W   = 8;

  typedef logic [SEG_COUNT-1:0] seg_mask_t;
  typedef logic [SEG_IDX_W-1:0] seg_idx_t;
  typedef logic [FRAC_W-1:0]    frac_t;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_SPACING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE   = 3'd7;

  // register reset values
  localparam logic signed [15:0] RST_ORIGIN_X     = 16'sd0;
  localparam logic signed [15:0] RST_ORIGIN_Y     = 16'sd0;
  localparam logic [SIZE_W-1:0]  RST_GLYPH_WIDTH  = 15'd819;
  localparam logic [SIZE_W-1:0]  RST_GLYPH_HEIGHT = 15'd1638;
  localparam logic signed [15:0] RST_CHAR_SPACING = 16'sd164;
  localparam logic [COLOR_W-1:0] RST_COLOR        = 8'd255;

  // segment ids, in emission order
  localparam seg_idx_t SEG_TOP      = 4'd0;
  localparam seg_idx_t SEG_UP_LEFT  = 4'd1;
  localparam seg_idx_t SEG_UP_RIGHT = 4'd2;
  localparam seg_idx_t SEG_MIDDLE   = 4'd3;
  localparam seg_idx_t SEG_LO_LEFT  = 4'd4;
  localparam seg_idx_t SEG_LO_RIGHT = 4'd5;
  localparam seg_idx_t SEG_BOTTOM   = 4'd6;
  localparam seg_idx_t SEG_COLON_HI = 4'd7;
  localparam seg_idx_t SEG_COLON_LO = 4'd8;

  // character codes
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // Q1.8 fractions, 256 is one
  localparam frac_t FR_ZERO = 9'd0;
  localparam frac_t FR_HALF = 9'd128;
  localparam frac_t FR_ONE  = 9'd256;
  localparam frac_t FR_0_45 = 9'd115;
  localparam frac_t FR_0_55 = 9'd141;
  localparam frac_t FR_0_62 = 9'd159;
  localparam frac_t FR_0_38 = 9'd97;

  typedef struct packed {
    frac_t sx;
    frac_t sy;
    frac_t ex;
    frac_t ey;
  } seg_frac_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic seg_mask_t glyph_mask(input logic [7:0] ch);
    seg_mask_t m;
    case (ch)
      CH_DIGIT0 + 8'd0: m = 9'h077;
      CH_DIGIT0 + 8'd1: m = 9'h024;
      CH_DIGIT0 + 8'd2: m = 9'h05D;
      CH_DIGIT0 + 8'd3: m = 9'h06D;
      CH_DIGIT0 + 8'd4: m = 9'h02E;
      CH_DIGIT0 + 8'd5: m = 9'h06B;
      CH_DIGIT0 + 8'd6: m = 9'h07B;
      CH_DIGIT0 + 8'd7: m = 9'h025;
      CH_DIGIT0 + 8'd8: m = 9'h07F;
      CH_DIGIT0 + 8'd9: m = 9'h06F;
      CH_F:             m = 9'h01B;
      CH_P:             m = 9'h01F;
      CH_S:             m = 9'h06B;
      CH_COLON:         m = 9'h180;
      CH_MINUS:         m = 9'h008;
      default:          m = '0;
    endcase
    return m;
  endfunction

  function automatic seg_frac_t seg_frac(input seg_idx_t seg);
    seg_frac_t f;
    case (seg)
      SEG_TOP:      f = '{FR_ZERO, FR_ONE,  FR_ONE,  FR_ONE};
      SEG_UP_LEFT:  f = '{FR_ZERO, FR_HALF, FR_ZERO, FR_ONE};
      SEG_UP_RIGHT: f = '{FR_ONE,  FR_HALF, FR_ONE,  FR_ONE};
      SEG_MIDDLE:   f = '{FR_ZERO, FR_HALF, FR_ONE,  FR_HALF};
      SEG_LO_LEFT:  f = '{FR_ZERO, FR_ZERO, FR_ZERO, FR_HALF};
      SEG_LO_RIGHT: f = '{FR_ONE,  FR_ZERO, FR_ONE,  FR_HALF};
      SEG_BOTTOM:   f = '{FR_ZERO, FR_ZERO, FR_ONE,  FR_ZERO};
      SEG_COLON_HI: f = '{FR_0_45, FR_0_62, FR_0_55, FR_0_62};
      SEG_COLON_LO: f = '{FR_0_45, FR_0_38, FR_0_55, FR_0_38};
      default:      f = '{FR_ZERO, FR_ZERO, FR_ZERO, FR_ZERO};
    endcase
    return f;
  endfunction

  // rounded offset (frac * size + 128) >> 8, never above 32767
  function automatic logic [SIZE_W-1:0] scale(input frac_t frac, input logic [SIZE_W-1:0] size);
    logic [FRAC_W+SIZE_W-1:0] prod;
    prod = frac * size + (FRAC_W+SIZE_W)'(128);
    return prod[SIZE_W+7:8];
  endfunction

endpackage

// ===== sv/stlg_front.sv =====
// front end: takes characters, looks up the glyph mask and keeps the pen position
// depends on stlg_pkg
module stlg_front #(
  parameter int COORD_WIDTH = stlg_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_start_of_text,
  input  logic signed [15:0]            cfg_origin_x,
  input  logic [stlg_pkg::SIZE_W-1:0]   cfg_glyph_width,
  input  logic signed [15:0]            cfg_char_spacing,
  input  stlg_pkg::q_status_t           q_status,
  output logic                          q_push,
  output logic [stlg_pkg::SEG_COUNT+COORD_WIDTH-1:0] q_data
);
  import stlg_pkg::*;

  localparam int SW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = SW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > CMAX) r = CMAX;
    else if (v < CMIN) r = CMIN;
    else r = v;
    return r[COORD_WIDTH-1:0];
  endfunction

  logic signed [COORD_WIDTH-1:0] pen_r, pen_nxt;
  logic signed [COORD_WIDTH-1:0] pen_base;
  seg_mask_t                     mask;
  logic                          accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign mask     = glyph_mask(in_char_code);
  assign pen_base = in_start_of_text ? sat(SW'(cfg_origin_x)) : pen_r;
  assign q_push   = accept && (mask != '0);
  assign q_data   = {mask, pen_base};

  always_comb begin
    pen_nxt = pen_r;
    if (accept) begin
      pen_nxt = sat(SW'(pen_base) + SW'($signed({1'b0, cfg_glyph_width}))
                    + SW'(cfg_char_spacing));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0;
    end else begin
      pen_r <= pen_nxt;
    end
  end

endmodule

// ===== sv/stlg_queue.sv =====
// two-entry queue between front and back end
// depends on stlg_pkg
module stlg_queue #(
  parameter int DATA_WIDTH = stlg_pkg::SEG_COUNT + stlg_pkg::DEF_COORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] head,
  output stlg_pkg::q_status_t   status
);
  import stlg_pkg::*;

  logic [DATA_WIDTH-1:0] head_r, head_nxt;
  logic [DATA_WIDTH-1:0] tail_r, tail_nxt;
  logic [1:0]            cnt_r, cnt_nxt;

  assign head         = head_r;
  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        head_nxt = push_data;
      end else begin
        head_nxt = tail_r;
        tail_nxt = push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) head_nxt = push_data;
      else tail_nxt = push_data;
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && status.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("pop from empty queue");

endmodule

// ===== sv/stlg_back.sv =====
// back end: walks the glyph mask, one segment per cycle while the output is not stalled, and builds the endpoints
// depends on stlg_pkg
module stlg_back #(
  parameter int COORD_WIDTH = stlg_pkg::DEF_COORD_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  stlg_pkg::q_status_t                        q_status,
  input  logic [stlg_pkg::SEG_COUNT+COORD_WIDTH-1:0] q_head,
  output logic                                       q_pop,
  input  logic signed [15:0]                         cfg_origin_y,
  input  logic [stlg_pkg::SIZE_W-1:0]                cfg_glyph_width,
  input  logic [stlg_pkg::SIZE_W-1:0]                cfg_glyph_height,
  input  logic [stlg_pkg::COLOR_W-1:0]               cfg_color_red,
  input  logic [stlg_pkg::COLOR_W-1:0]               cfg_color_green,
  input  logic [stlg_pkg::COLOR_W-1:0]               cfg_color_blue,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [COORD_WIDTH-1:0]              out_start_x,
  output logic signed [COORD_WIDTH-1:0]              out_start_y,
  output logic signed [COORD_WIDTH-1:0]              out_end_x,
  output logic signed [COORD_WIDTH-1:0]              out_end_y,
  output logic [stlg_pkg::COLOR_W-1:0]               out_red,
  output logic [stlg_pkg::COLOR_W-1:0]               out_green,
  output logic [stlg_pkg::COLOR_W-1:0]               out_blue,
  output logic                                       out_last_in_glyph
);
  import stlg_pkg::*;

  localparam int SW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = SW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > CMAX) r = CMAX;
    else if (v < CMIN) r = CMIN;
    else r = v;
    return r[COORD_WIDTH-1:0];
  endfunction

  // current glyph
  logic                          cur_valid_r, cur_valid_nxt;
  seg_mask_t                     rem_r, rem_nxt;
  logic signed [COORD_WIDTH-1:0] cur_pen_r, cur_pen_nxt;

  // offset stage
  logic                          s1_valid_r;
  logic [SIZE_W-1:0]             s1_off_sx_r, s1_off_sy_r, s1_off_ex_r, s1_off_ey_r;
  logic signed [COORD_WIDTH-1:0] s1_pen_r;
  logic                          s1_last_r;

  // output register
  logic                          out_valid_r;
  logic signed [COORD_WIDTH-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COLOR_W-1:0]            red_r, green_r, blue_r;
  logic                          last_r;

  logic      out_adv, s1_ready, issue, seg_last, found;
  seg_idx_t  seg;
  seg_mask_t rem_left;
  seg_frac_t frac;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || out_adv;
  assign issue    = cur_valid_r && s1_ready;
  assign rem_left = rem_r & (rem_r - seg_mask_t'(1));
  assign seg_last = (rem_left == '0);
  assign q_pop    = !q_status.empty && (!cur_valid_r || (issue && seg_last));
  assign frac     = seg_frac(seg);

  // lowest pending segment
  always_comb begin
    seg   = '0;
    found = 1'b0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (!found && rem_r[i]) begin
        seg   = SEG_IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    rem_nxt       = rem_r;
    cur_pen_nxt   = cur_pen_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      rem_nxt       = q_head[SEG_COUNT+COORD_WIDTH-1:COORD_WIDTH];
      cur_pen_nxt   = q_head[COORD_WIDTH-1:0];
    end else if (issue) begin
      rem_nxt = rem_left;
      if (seg_last) cur_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (s1_ready) s1_valid_r <= issue;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    cur_pen_r <= cur_pen_nxt;
    if (issue) begin
      s1_off_sx_r <= scale(frac.sx, cfg_glyph_width);
      s1_off_sy_r <= scale(FR_ONE - frac.sy, cfg_glyph_height);
      s1_off_ex_r <= scale(frac.ex, cfg_glyph_width);
      s1_off_ey_r <= scale(FR_ONE - frac.ey, cfg_glyph_height);
      s1_pen_r    <= cur_pen_r;
      s1_last_r   <= seg_last;
    end
    if (out_adv && s1_valid_r) begin
      sx_r    <= sat(SW'(s1_pen_r) + SW'($signed({1'b0, s1_off_sx_r})));
      sy_r    <= sat(SW'(cfg_origin_y) + SW'($signed({1'b0, s1_off_sy_r})));
      ex_r    <= sat(SW'(s1_pen_r) + SW'($signed({1'b0, s1_off_ex_r})));
      ey_r    <= sat(SW'(cfg_origin_y) + SW'($signed({1'b0, s1_off_ey_r})));
      red_r   <= cfg_color_red;
      green_r <= cfg_color_green;
      blue_r  <= cfg_color_blue;
      last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_start_x       = sx_r;
  assign out_start_y       = sy_r;
  assign out_end_x         = ex_r;
  assign out_end_y         = ey_r;
  assign out_red           = red_r;
  assign out_green         = green_r;
  assign out_blue          = blue_r;
  assign out_last_in_glyph = last_r;

  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (rem_r != '0))
    else $error("active glyph with no pending segment");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_off_sx_r) && $stable(s1_last_r)))
    else $error("offset stage changed while output stalled");

endmodule

// ===== sv/segment_text_line_generator.sv =====
// Seven-segment vector text generator: each character item becomes one output item per
// lit segment (top, upper left, upper right, middle, lower left, lower right, bottom; the
// colon gives two short dashes, upper first), with Q2.14 endpoints saturated to COORD_WIDTH
// bits. The back end emits one segment per cycle while the output is not stalled; a glyph
// has at most seven segments and glyphs follow each other without a gap. A character with
// no glyph is not queued and only moves the pen. The first segment of a character goes
// through the queue, the current glyph register, the offset stage and the output register.
// A two-entry queue between the front and back end absorbs short output stalls. The user
// must see that configuration is written only while idle; the block does not enforce it.
module segment_text_line_generator #(
  parameter int COORD_WIDTH = stlg_pkg::DEF_COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [stlg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stlg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_start_of_text,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_start_x,
  output logic signed [COORD_WIDTH-1:0]       out_start_y,
  output logic signed [COORD_WIDTH-1:0]       out_end_x,
  output logic signed [COORD_WIDTH-1:0]       out_end_y,
  output logic [stlg_pkg::COLOR_W-1:0]        out_red,
  output logic [stlg_pkg::COLOR_W-1:0]        out_green,
  output logic [stlg_pkg::COLOR_W-1:0]        out_blue,
  output logic                                out_last_in_glyph
);
  import stlg_pkg::*;

  localparam int QW = SEG_COUNT + COORD_WIDTH;

  logic signed [15:0] origin_x_r, origin_y_r, char_spacing_r;
  logic [SIZE_W-1:0]  glyph_width_r, glyph_height_r;
  logic [COLOR_W-1:0] color_red_r, color_green_r, color_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= RST_ORIGIN_X;
      origin_y_r     <= RST_ORIGIN_Y;
      glyph_width_r  <= RST_GLYPH_WIDTH;
      glyph_height_r <= RST_GLYPH_HEIGHT;
      char_spacing_r <= RST_CHAR_SPACING;
      color_red_r    <= RST_COLOR;
      color_green_r  <= RST_COLOR;
      color_blue_r   <= RST_COLOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORIGIN_X:     origin_x_r     <= $signed(cfg_data);
        REG_ORIGIN_Y:     origin_y_r     <= $signed(cfg_data);
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[SIZE_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[SIZE_W-1:0];
        REG_CHAR_SPACING: char_spacing_r <= $signed(cfg_data);
        REG_COLOR_RED:    color_red_r    <= cfg_data[COLOR_W-1:0];
        REG_COLOR_GREEN:  color_green_r  <= cfg_data[COLOR_W-1:0];
        REG_COLOR_BLUE:   color_blue_r   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  q_status_t      q_status;
  logic           q_push, q_pop;
  logic [QW-1:0]  q_data, q_head;

  stlg_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_start_of_text (in_start_of_text),
    .cfg_origin_x     (origin_x_r),
    .cfg_glyph_width  (glyph_width_r),
    .cfg_char_spacing (char_spacing_r),
    .q_status         (q_status),
    .q_push           (q_push),
    .q_data           (q_data)
  );

  stlg_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  stlg_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .cfg_origin_y      (origin_y_r),
    .cfg_glyph_width   (glyph_width_r),
    .cfg_glyph_height  (glyph_height_r),
    .cfg_color_red     (color_red_r),
    .cfg_color_green   (color_green_r),
    .cfg_color_blue    (color_blue_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_start_x       (out_start_x),
    .out_start_y       (out_start_y),
    .out_end_x         (out_end_x),
    .out_end_y         (out_end_y),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_in_glyph (out_last_in_glyph)
  );

endmodule
